[rtl/core/urf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package urf_pkg;

  // default receive fifo depth in bytes
  localparam int FIFO_DEPTH = 8;

  // item actions
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_RX    = 2'd2;

  // register indexes
  localparam logic [2:0] REG_TXDATA  = 3'd0;
  localparam logic [2:0] REG_RXDATA  = 3'd1;
  localparam logic [2:0] REG_TXCTRL  = 3'd2;
  localparam logic [2:0] REG_RXCTRL  = 3'd3;
  localparam logic [2:0] REG_IE      = 3'd4;
  localparam logic [2:0] REG_IP      = 3'd5;
  localparam logic [2:0] REG_DIV     = 3'd6;

  // word returned by an rxdata read of an empty fifo
  localparam logic [31:0] RX_EMPTY_WORD = 32'h8000_0000;

  // position of the watermark bit in enable and pending
  localparam int WM_BIT = 1;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  reg_index;
    logic [31:0] write_data;
    logic [7:0]  rx_byte;
  } cmd_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        irq_level;
    logic        rx_dropped;
    logic        bus_error;
    logic        rx_ready;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/urf_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module urf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/uart_rx_fifo_registers.sv]
`timescale 1ns / 1ps
`default_nettype none

// uart register block with receive fifo
// the done strobe is registered at the accepting edge
// throughput: one item per cycle; busy is never raised, the receiver cannot stall
// reset (sync, active high) empties the fifo and clears all control registers;
// fifo storage is not cleared, only written entries are ever read
module uart_rx_fifo_registers
  import urf_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  output logic         busy,
  input  wire cmd_t    cmd,
  output logic         done,
  output result_t      result
);

  // fifo index, occupancy and wrap-sum widths
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;

  // architectural state
  logic [CW-1:0] rx_count, rx_count_next;
  logic [AW-1:0] rx_head, rx_head_next;
  logic [31:0]   int_enable, int_enable_next;
  logic [31:0]   tx_control, tx_control_next;
  logic [31:0]   rx_control, rx_control_next;
  logic [31:0]   baud_divisor, baud_divisor_next;

  // result register; read data of a pop comes from the ram output register
  result_t res, res_next;
  logic    pop_sel, pop_sel_next;
  logic    done_next;

  // fifo ram interface
  logic          push;
  logic [AW-1:0] waddr;
  logic [SW-1:0] wsum;
  logic [7:0]    ram_rdata;

  logic accept;
  logic empty, full;
  logic [AW-1:0] head_inc;

  // every cycle can take a transfer
  assign busy   = 1'b0;
  assign accept = start;

  assign empty = (rx_count == '0);
  assign full  = (rx_count == CW'(DEPTH));

  // head advance with wrap at the depth
  assign head_inc = (rx_head == AW'(DEPTH - 1)) ? '0 : rx_head + AW'(1);

  // tail slot: head plus count, one compare and subtract for the wrap
  assign wsum  = SW'(rx_head) + SW'(rx_count);
  assign waddr = (wsum >= SW'(DEPTH)) ? AW'(wsum - SW'(DEPTH)) : AW'(wsum);

  urf_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_rx_ram (
    .clk  (clk),
    .we   (push),
    .waddr(waddr),
    .wdata(cmd.rx_byte),
    .raddr(rx_head),
    .rdata(ram_rdata)
  );

  always_comb begin
    rx_count_next     = rx_count;
    rx_head_next      = rx_head;
    int_enable_next   = int_enable;
    tx_control_next   = tx_control;
    rx_control_next   = rx_control;
    baud_divisor_next = baud_divisor;
    push              = 1'b0;
    pop_sel_next      = 1'b0;
    res_next          = '0;
    done_next         = accept;

    if (accept) begin
      case (cmd.action)
        ACT_READ: begin
          case (cmd.reg_index)
            REG_TXDATA: res_next.read_data = '0;
            REG_RXDATA: begin
              if (!empty) begin
                // data shows up from the ram register next cycle
                pop_sel_next  = 1'b1;
                rx_head_next  = head_inc;
                rx_count_next = rx_count - CW'(1);
              end else begin
                res_next.read_data = RX_EMPTY_WORD;
              end
            end
            REG_TXCTRL: res_next.read_data = tx_control;
            REG_RXCTRL: res_next.read_data = rx_control;
            REG_IE:     res_next.read_data = int_enable;
            REG_IP:     res_next.read_data[WM_BIT] = !empty;
            REG_DIV:    res_next.read_data = baud_divisor;
            default:    res_next.bus_error = 1'b1;
          endcase
        end
        ACT_WRITE: begin
          case (cmd.reg_index)
            REG_TXDATA: begin
              res_next.tx_valid = 1'b1;
              res_next.tx_byte  = cmd.write_data[7:0];
            end
            REG_TXCTRL: tx_control_next   = cmd.write_data;
            REG_RXCTRL: rx_control_next   = cmd.write_data;
            REG_IE:     int_enable_next   = cmd.write_data;
            REG_DIV:    baud_divisor_next = cmd.write_data;
            default:    res_next.bus_error = 1'b1;
          endcase
        end
        ACT_RX: begin
          if (full) begin
            res_next.rx_dropped = 1'b1;
          end else begin
            push          = 1'b1;
            rx_count_next = rx_count + CW'(1);
          end
        end
        default: begin
          // unused action: no effect
        end
      endcase
    end

    // status flags reflect the state after this transfer
    res_next.irq_level = int_enable_next[WM_BIT] && (rx_count_next != '0);
    res_next.rx_ready  = (rx_count_next != CW'(DEPTH));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_count     <= '0;
      rx_head      <= '0;
      int_enable   <= '0;
      tx_control   <= '0;
      rx_control   <= '0;
      baud_divisor <= '0;
      done         <= 1'b0;
    end else begin
      rx_count     <= rx_count_next;
      rx_head      <= rx_head_next;
      int_enable   <= int_enable_next;
      tx_control   <= tx_control_next;
      rx_control   <= rx_control_next;
      baud_divisor <= baud_divisor_next;
      done         <= done_next;
    end
  end

  // payload registers need no reset
  always_ff @(posedge clk) begin
    res     <= res_next;
    pop_sel <= pop_sel_next;
  end

  always_comb begin
    result = res;
    if (pop_sel) begin
      result.read_data = {24'h0, ram_rdata};
    end
  end

endmodule

`default_nettype wire
